### rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by the queue cells, the top level and the port checker.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;
  localparam int VAL_W       = 32;
  localparam int PRI_W       = 16;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // One slot of the sorted chain.
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
  } spq_entry_t;

  // Operation broadcast to every cell in the same cycle.
  typedef struct packed {
    logic                    enq;
    logic                    deq;
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
  } spq_cmd_t;

endpackage

### rtl/core/spq_cell.sv
// One cell of the sorted chain: holds a single entry and exchanges it
// with its neighbors on enqueue and dequeue. Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  spq_cmd_t   cmd,
  input  spq_entry_t prev_entry,
  input  logic       prev_stay,
  input  spq_entry_t next_entry,
  output spq_entry_t entry,
  output logic       stay
);

  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic signed [PRI_W-1:0] prio_r, prio_nxt;

  // An entry with priority at or above the new one keeps its place, so
  // equal priorities are served in arrival order.
  assign stay  = valid_r && (prio_r >= cmd.prio);
  assign entry = '{valid: valid_r, value: value_r, prio: prio_r};

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (cmd.enq && !stay) begin
      if (prev_stay) begin
        valid_nxt = 1'b1;
        value_nxt = cmd.value;
        prio_nxt  = cmd.prio;
      end else begin
        valid_nxt = prev_entry.valid;
        value_nxt = prev_entry.value;
        prio_nxt  = prev_entry.prio;
      end
    end else if (cmd.deq) begin
      valid_nxt = next_entry.valid;
      value_nxt = next_entry.value;
      prio_nxt  = next_entry.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

endmodule

### rtl/core/sorted_priority_queue.sv
// Sorted priority queue top level: a chain of QUEUE_DEPTH cells kept in
// descending priority order, and a registered result stage.
// A result is registered when its request is accepted and appears in the next cycle.
// Throughput: one request per cycle while in_stall is low; every cell compares and shifts at once.
// Reset (synchronous, active low) empties the queue and the result stage.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_opcode,
  input  logic signed [VAL_W-1:0] in_item_value,
  input  logic signed [PRI_W-1:0] in_item_priority,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_value,
  output logic signed [PRI_W-1:0] out_priority,
  output logic [1:0]              out_status,
  output logic [OCC_W-1:0]        out_occupancy
);

  spq_entry_t ent  [QUEUE_DEPTH];
  logic       stay [QUEUE_DEPTH];
  spq_cmd_t   cmd;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic signed [PRI_W-1:0] out_prio_r, out_prio_nxt;
  spq_status_t             out_status_r, out_status_nxt;
  logic [OCC_W-1:0]        out_occ_r;

  logic accept, full, empty, enq_ok, deq_ok;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    enq_ok         = 1'b0;
    deq_ok         = 1'b0;
    out_value_nxt  = '0;
    out_prio_nxt   = '0;
    out_status_nxt = ST_OK;
    unique case (in_opcode)
      OP_ENQUEUE: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          enq_ok = accept;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          deq_ok        = accept && (in_opcode == OP_DEQUEUE);
          out_value_nxt = ent[0].value;
          out_prio_nxt  = ent[0].prio;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd = '{enq: enq_ok, deq: deq_ok, value: in_item_value, prio: in_item_priority};

  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  genvar k;
  generate
    for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      spq_entry_t prev_e, next_e;
      logic       prev_s;
      if (k == 0) begin : g_head
        assign prev_e = '0;
        assign prev_s = 1'b1;
      end else begin : g_body
        assign prev_e = ent[k-1];
        assign prev_s = stay[k-1];
      end
      if (k == QUEUE_DEPTH - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_link
        assign next_e = ent[k+1];
      end
      spq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .prev_entry (prev_e),
        .prev_stay  (prev_s),
        .next_entry (next_e),
        .entry      (ent[k]),
        .stay       (stay[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= out_value_nxt;
      out_prio_r   <= out_prio_nxt;
      out_status_r <= out_status_nxt;
      out_occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_priority  = out_prio_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule

### rtl/core/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg.
module spq_checker
  import spq_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic signed [VAL_W-1:0] out_value,
  input logic signed [PRI_W-1:0] out_priority,
  input logic [1:0]              out_status,
  input logic [OCC_W-1:0]        out_occupancy
);

  // The input side only backs up while a result is waiting.
  a_stall_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with no pending result");

  // An accepted request always produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid) else $error("request gave no result");

  // An underflow report means the queue was empty.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_occupancy == '0) &&
    (out_value == '0) && (out_priority == '0))
    else $error("underflow reported with entries held");

  // An overflow report means the queue was full.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |->
    (out_occupancy == OCC_W'(QUEUE_DEPTH)))
    else $error("overflow reported below full");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
